// ===== sv/qvr_pkg.sv =====
package qvr_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int CQ_WIDTH   = QUAT_WIDTH + 1;
  localparam int ACC_WIDTH  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = QUAT_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W  = 3'd0,
    REG_QUAT_X  = 3'd1,
    REG_QUAT_Y  = 3'd2,
    REG_QUAT_Z  = 3'd3,
    REG_INVERSE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [CQ_WIDTH-1:0] w;
    logic signed [CQ_WIDTH-1:0] a;
    logic signed [CQ_WIDTH-1:0] b;
    logic signed [CQ_WIDTH-1:0] c;
  } quat_t;

endpackage

// ===== sv/qvr_intermediate.sv =====
module qvr_intermediate #(
  parameter int VEC_WIDTH = 16,
  localparam int PROD_W = VEC_WIDTH + qvr_pkg::CQ_WIDTH,
  localparam int T_W = PROD_W + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [VEC_WIDTH-1:0] x,
  input  logic signed [VEC_WIDTH-1:0] y,
  input  logic signed [VEC_WIDTH-1:0] z,
  input  qvr_pkg::quat_t              quat,
  output logic                        out_valid,
  output logic signed [T_W-1:0]       t0,
  output logic signed [T_W-1:0]       t1,
  output logic signed [T_W-1:0]       t2,
  output logic signed [T_W-1:0]       t3
);

  logic signed [qvr_pkg::CQ_WIDTH-1:0] qw, qa, qb, qc;
  logic signed [PROD_W-1:0] p_nxt [12];
  logic signed [PROD_W-1:0] p_r   [12];
  logic signed [T_W-1:0]    t_nxt [4];
  logic signed [T_W-1:0]    t_r   [4];
  logic                     v1_r, v2_r;

  assign qw = $signed(quat.w);
  assign qa = $signed(quat.a);
  assign qb = $signed(quat.b);
  assign qc = $signed(quat.c);

  always_comb begin
    p_nxt[0]  = x * qa;
    p_nxt[1]  = y * qb;
    p_nxt[2]  = z * qc;
    p_nxt[3]  = x * qw;
    p_nxt[4]  = z * qb;
    p_nxt[5]  = y * qc;
    p_nxt[6]  = y * qw;
    p_nxt[7]  = z * qa;
    p_nxt[8]  = x * qc;
    p_nxt[9]  = z * qw;
    p_nxt[10] = y * qa;
    p_nxt[11] = x * qb;
  end

  always_comb begin
    t_nxt[0] = T_W'(p_r[0]) + T_W'(p_r[1])  + T_W'(p_r[2]);
    t_nxt[1] = T_W'(p_r[3]) + T_W'(p_r[4])  - T_W'(p_r[5]);
    t_nxt[2] = T_W'(p_r[6]) - T_W'(p_r[7])  + T_W'(p_r[8]);
    t_nxt[3] = T_W'(p_r[9]) + T_W'(p_r[10]) - T_W'(p_r[11]);
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    t_r <= t_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign t0 = t_r[0];
  assign t1 = t_r[1];
  assign t2 = t_r[2];
  assign t3 = t_r[3];

  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r == ($past(v1_r) && $past(rst_n)))
    else $error("intermediate valid lost or invented");

  a_zero_vector: assert property (@(posedge clk)
    $past(x == '0 && y == '0 && z == '0, 2) |->
      (t_r[0] == '0 && t_r[1] == '0 && t_r[2] == '0 && t_r[3] == '0))
    else $error("zero vector gave nonzero intermediate");

endmodule

// ===== sv/qvr_product.sv =====
module qvr_product #(
  parameter int T_W = 35,
  localparam int P2_W = T_W + qvr_pkg::CQ_WIDTH,
  localparam int ACC_W = qvr_pkg::ACC_WIDTH,
  localparam int EXT_W = (P2_W > ACC_W) ? P2_W : ACC_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  qvr_pkg::quat_t          quat,
  input  logic signed [T_W-1:0]   t0,
  input  logic signed [T_W-1:0]   t1,
  input  logic signed [T_W-1:0]   t2,
  input  logic signed [T_W-1:0]   t3,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] sx,
  output logic signed [ACC_W-1:0] sy,
  output logic signed [ACC_W-1:0] sz
);

  logic signed [qvr_pkg::CQ_WIDTH-1:0] qw, qa, qb, qc;
  logic signed [P2_W-1:0]  p_nxt [12];
  logic signed [P2_W-1:0]  p_r   [12];
  logic signed [ACC_W-1:0] e     [12];
  logic signed [ACC_W-1:0] s_nxt [3];
  logic signed [ACC_W-1:0] s_r   [3];
  logic                    v1_r, v2_r;

  assign qw = $signed(quat.w);
  assign qa = $signed(quat.a);
  assign qb = $signed(quat.b);
  assign qc = $signed(quat.c);

  always_comb begin
    p_nxt[0]  = qa * t0;
    p_nxt[1]  = qw * t1;
    p_nxt[2]  = qc * t2;
    p_nxt[3]  = qb * t3;
    p_nxt[4]  = qb * t0;
    p_nxt[5]  = qc * t1;
    p_nxt[6]  = qw * t2;
    p_nxt[7]  = qa * t3;
    p_nxt[8]  = qc * t0;
    p_nxt[9]  = qb * t1;
    p_nxt[10] = qa * t2;
    p_nxt[11] = qw * t3;
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      e[i] = ACC_W'(EXT_W'(p_r[i]));
    end
    s_nxt[0] = e[0] + e[1]  - e[2]  + e[3];
    s_nxt[1] = e[4] + e[5]  + e[6]  - e[7];
    s_nxt[2] = e[8] - e[9]  + e[10] + e[11];
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    s_r <= s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign sx = s_r[0];
  assign sy = s_r[1];
  assign sz = s_r[2];

endmodule

// ===== sv/qvr_round.sv =====
module qvr_round #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC_BITS = 15,
  localparam int ACC_W = qvr_pkg::ACC_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [ACC_W-1:0]     sx,
  input  logic signed [ACC_W-1:0]     sy,
  input  logic signed [ACC_W-1:0]     sz,
  output logic                        out_valid,
  output logic signed [VEC_WIDTH-1:0] x,
  output logic signed [VEC_WIDTH-1:0] y,
  output logic signed [VEC_WIDTH-1:0] z,
  output logic                        saturated
);

  localparam int SH = 2 * QUAT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (SH - 1);
  localparam logic signed [ACC_W-1:0] HI = (ACC_W'(1) << (VEC_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO = -HI - ACC_W'(1);
  localparam logic signed [VEC_WIDTH-1:0] MAXV = HI[VEC_WIDTH-1:0];
  localparam logic signed [VEC_WIDTH-1:0] MINV = LO[VEC_WIDTH-1:0];

  logic signed [ACC_W-1:0]     acc  [3];
  logic signed [ACC_W-1:0]     rnd  [3];
  logic signed [ACC_W-1:0]     q    [3];
  logic [2:0]                  hi_c, lo_c;
  logic signed [VEC_WIDTH-1:0] v_nxt [3];
  logic signed [VEC_WIDTH-1:0] v_r   [3];
  logic                        sat_nxt, sat_r, valid_r;

  assign acc[0] = sx;
  assign acc[1] = sy;
  assign acc[2] = sz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = acc[i] + RND;
      q[i]    = rnd[i] >>> SH;
      hi_c[i] = q[i] > HI;
      lo_c[i] = q[i] < LO;
      if (hi_c[i]) begin
        v_nxt[i] = MAXV;
      end else if (lo_c[i]) begin
        v_nxt[i] = MINV;
      end else begin
        v_nxt[i] = q[i][VEC_WIDTH-1:0];
      end
    end
    sat_nxt = (|hi_c) | (|lo_c);
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    sat_r <= sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  assign out_valid = valid_r;
  assign x = v_r[0];
  assign y = v_r[1];
  assign z = v_r[2];
  assign saturated = sat_r;

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && sat_r) |->
      (v_r[0] == MAXV || v_r[0] == MINV || v_r[1] == MAXV || v_r[1] == MINV ||
       v_r[2] == MAXV || v_r[2] == MINV))
    else $error("saturation flag without a clipped component");

  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r == ($past(in_valid) && $past(rst_n)))
    else $error("output strobe does not follow the sum stage");

endmodule

// ===== sv/quaternion_vector_rotate.sv =====
// Channel  Ports                                    Handshake
// -------  ---------------------------------------  -------------------------------
// input    in_vec_x_in, in_vec_y_in, in_vec_z_in    start high and busy low at clk
// result   out_vec_{x,y,z}_out, out_saturated       out_valid, a one-cycle strobe per item
// config   cfg_index, cfg_wdata                     cfg_we at clk, no wait
//
// One item per cycle; the pipeline has six register stages: input, first products,
// intermediate sums, second products, final sums, round and saturate.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
// Synchronous reset clears the valid bits and loads the identity quaternion.
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_x_in,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_y_in,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_z_in,
  output logic                                out_valid,
  output logic signed [VEC_WIDTH-1:0]         out_vec_x_out,
  output logic signed [VEC_WIDTH-1:0]         out_vec_y_out,
  output logic signed [VEC_WIDTH-1:0]         out_vec_z_out,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int T_W = VEC_WIDTH + qvr_pkg::CQ_WIDTH + 2;
  localparam int ACC_W = qvr_pkg::ACC_WIDTH;
  localparam int QW = qvr_pkg::QUAT_WIDTH;
  localparam int CQW = qvr_pkg::CQ_WIDTH;

  logic signed [QW-1:0] quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic                 inverse_r;
  qvr_pkg::quat_t       quat;
  logic signed [CQW-1:0] ex, ey, ez;

  logic                        in_v_r;
  logic signed [VEC_WIDTH-1:0] in_x_r, in_y_r, in_z_r;

  logic                  t_valid;
  logic signed [T_W-1:0] t0, t1, t2, t3;
  logic                    s_valid;
  logic signed [ACC_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r  <= QW'(32767);
      quat_x_r  <= '0;
      quat_y_r  <= '0;
      quat_z_r  <= '0;
      inverse_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (qvr_pkg::reg_idx_t'(cfg_index))
        qvr_pkg::REG_QUAT_W:  quat_w_r  <= cfg_wdata;
        qvr_pkg::REG_QUAT_X:  quat_x_r  <= cfg_wdata;
        qvr_pkg::REG_QUAT_Y:  quat_y_r  <= cfg_wdata;
        qvr_pkg::REG_QUAT_Z:  quat_z_r  <= cfg_wdata;
        qvr_pkg::REG_INVERSE: inverse_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ex = CQW'(quat_x_r);
  assign ey = CQW'(quat_y_r);
  assign ez = CQW'(quat_z_r);

  always_comb begin
    quat.w = CQW'(quat_w_r);
    quat.a = inverse_r ? -ex : ex;
    quat.b = inverse_r ? -ey : ey;
    quat.c = inverse_r ? -ez : ez;
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    in_x_r <= in_vec_x_in;
    in_y_r <= in_vec_y_in;
    in_z_r <= in_vec_z_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  qvr_intermediate #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_inter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_v_r),
    .x         (in_x_r),
    .y         (in_y_r),
    .z         (in_z_r),
    .quat      (quat),
    .out_valid (t_valid),
    .t0        (t0),
    .t1        (t1),
    .t2        (t2),
    .t3        (t3)
  );

  qvr_product #(
    .T_W (T_W)
  ) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t_valid),
    .quat      (quat),
    .t0        (t0),
    .t1        (t1),
    .t2        (t2),
    .t3        (t3),
    .out_valid (s_valid),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz)
  );

  qvr_round #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz),
    .out_valid (out_valid),
    .x         (out_vec_x_out),
    .y         (out_vec_y_out),
    .z         (out_vec_z_out),
    .saturated (out_saturated)
  );

endmodule

// ===== test/quaternion_vector_rotate_tb.sv =====
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;

  localparam int VW = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint ROUND_HALF = 64'sd536870912;
  localparam longint SAT_MAX = 32767;
  localparam longint SAT_MIN = -32768;

  typedef struct {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 sat;
  } rotated_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [VW-1:0] in_vec_x_in = '0;
  logic signed [VW-1:0] in_vec_y_in = '0;
  logic signed [VW-1:0] in_vec_z_in = '0;
  logic out_valid;
  logic signed [VW-1:0] out_vec_x_out;
  logic signed [VW-1:0] out_vec_y_out;
  logic signed [VW-1:0] out_vec_z_out;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qvr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic signed [15:0] mq_w = 16'sd32767;
  logic signed [15:0] mq_a = '0;
  logic signed [15:0] mq_b = '0;
  logic signed [15:0] mq_c = '0;
  logic mq_inverse = 1'b0;

  rotated_vec_t pending_rotations[$];
  int err_count = 0;
  int cycle_count = 0;

  quaternion_vector_rotate #(
    .VEC_WIDTH(VW),
    .QUAT_FRAC_BITS(15)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_vec_x_in(in_vec_x_in),
    .in_vec_y_in(in_vec_y_in),
    .in_vec_z_in(in_vec_z_in),
    .out_valid(out_valid),
    .out_vec_x_out(out_vec_x_out),
    .out_vec_y_out(out_vec_y_out),
    .out_vec_z_out(out_vec_z_out),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quaternion_vector_rotate_tb: done, errors");
      $finish;
    end
  end

  function automatic rotated_vec_t rotate_vector(logic signed [VW-1:0] vx,
                                                 logic signed [VW-1:0] vy,
                                                 logic signed [VW-1:0] vz);
    rotated_vec_t res;
    longint x, y, z, w, a, b, c;
    longint t0, t1, t2, t3;
    longint acc[3];
    longint r;
    logic signed [VW-1:0] comp[3];
    bit clip;
    x = vx;
    y = vy;
    z = vz;
    w = mq_w;
    a = mq_a;
    b = mq_b;
    c = mq_c;
    clip = 1'b0;
    if (mq_inverse) begin
      a = -a;
      b = -b;
      c = -c;
    end
    t0 = x * a + y * b + z * c;
    t1 = x * w + z * b - y * c;
    t2 = y * w - z * a + x * c;
    t3 = z * w + y * a - x * b;
    acc[0] = a * t0 + w * t1 - c * t2 + b * t3;
    acc[1] = b * t0 + c * t1 + w * t2 - a * t3;
    acc[2] = c * t0 - b * t1 + a * t2 + w * t3;
    for (int i = 0; i < 3; i++) begin
      r = (acc[i] + ROUND_HALF) >>> 30;
      if (r > SAT_MAX) begin
        r = SAT_MAX;
        clip = 1'b1;
      end
      if (r < SAT_MIN) begin
        r = SAT_MIN;
        clip = 1'b1;
      end
      comp[i] = r[VW-1:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.sat = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  always @(posedge clk) begin
    rotated_vec_t want;
    if (rst_n && out_valid) begin
      if (pending_rotations.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_rotations.pop_front();
        if (out_vec_x_out !== want.x) report_mismatch("vec_x_out", out_vec_x_out, want.x);
        if (out_vec_y_out !== want.y) report_mismatch("vec_y_out", out_vec_y_out, want.y);
        if (out_vec_z_out !== want.z) report_mismatch("vec_z_out", out_vec_z_out, want.z);
        if (out_saturated !== want.sat) report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

  task automatic send_vector(input logic signed [VW-1:0] vx, input logic signed [VW-1:0] vy,
                             input logic signed [VW-1:0] vz);
    @(negedge clk);
    start = 1'b1;
    in_vec_x_in = vx;
    in_vec_y_in = vy;
    in_vec_z_in = vz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rotations.push_back(rotate_vector(vx, vy, vz));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      in_vec_x_in = 16'($urandom);
      in_vec_y_in = 16'($urandom);
      in_vec_z_in = 16'($urandom);
    end
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start = 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [qvr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qvr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      qvr_pkg::REG_QUAT_W:  mq_w = data;
      qvr_pkg::REG_QUAT_X:  mq_a = data;
      qvr_pkg::REG_QUAT_Y:  mq_b = data;
      qvr_pkg::REG_QUAT_Z:  mq_c = data;
      qvr_pkg::REG_INVERSE: mq_inverse = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_quat(input logic [15:0] w, input logic [15:0] a, input logic [15:0] b,
                          input logic [15:0] c, input logic inv);
    cfg_write(qvr_pkg::REG_QUAT_W, w);
    cfg_write(qvr_pkg::REG_QUAT_X, a);
    cfg_write(qvr_pkg::REG_QUAT_Y, b);
    cfg_write(qvr_pkg::REG_QUAT_Z, c);
    cfg_write(qvr_pkg::REG_INVERSE, {15'($urandom_range(0, 32767)), inv});
  endtask

  function automatic logic [15:0] extreme_word();
    case ($urandom_range(0, 2))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] random_quat_word(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32767) - 16384);
      2: return extreme_word();
      default: return 16'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic signed [VW-1:0] random_component();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 511) - 256);
      1: return extreme_word();
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_random_config(input int kind);
    logic [15:0] w;
    w = (kind == 3) ? 16'(30000 + $urandom_range(0, 2767)) : random_quat_word(kind);
    set_quat(w, random_quat_word(kind), random_quat_word(kind), random_quat_word(kind),
             1'($urandom_range(0, 1)));
  endtask

  task automatic test_identity_extremes();
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh0000, 16'sh0000, 16'sh0000);
    send_vector(16'sh0001, 16'shffff, 16'sh0000);
    send_vector(16'sh7fff, 16'sh8000, 16'sh0001);
  endtask

  task automatic test_quarter_turn();
    drain_pipeline();
    set_quat(16'd23170, 16'd0, 16'd0, 16'd23170, 1'b0);
    send_vector(16'sh7fff, 16'sh0000, 16'sh0000);
    send_vector(16'sh0000, 16'sh8000, 16'sh0000);
    drain_pipeline();
    cfg_write(qvr_pkg::REG_INVERSE, 16'h0001);
    send_vector(16'sh7fff, 16'sh0000, 16'sh0000);
    send_vector(16'sh8000, 16'sh7fff, 16'sh8000);
  endtask

  task automatic test_conjugate_min();
    drain_pipeline();
    set_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
    send_vector(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    drain_pipeline();
    set_quat(16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_vector(16'sh7fff, 16'sh8000, 16'sh7fff);
    drain_pipeline();
    cfg_write(qvr_pkg::REG_INVERSE, 16'h0000);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_non_unit();
    drain_pipeline();
    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(16'sh8000, 16'sh0001, 16'shffff);
    drain_pipeline();
    set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_vector(16'sd100, -16'sd200, 16'sd300);
  endtask

  task automatic test_register_masking();
    drain_pipeline();
    set_quat(16'd20000, 16'd12000, -16'sd9000, 16'd5000, 1'b1);
    for (int i = qvr_pkg::REG_INVERSE + 1; i < (1 << qvr_pkg::CFG_IDX_W); i++) begin
      cfg_write(qvr_pkg::CFG_IDX_W'(i), qvr_pkg::CFG_DATA_W'($urandom));
    end
    cfg_write(qvr_pkg::REG_INVERSE, 16'hfffe);
    send_vector(16'sd12345, -16'sd23456, 16'sd30000);
    drain_pipeline();
    cfg_write(qvr_pkg::REG_INVERSE, 16'h8001);
    cfg_write(qvr_pkg::REG_QUAT_W, 16'h8000);
    send_vector(-16'sd12345, 16'sd23456, -16'sd30000);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      drain_pipeline();
      pick_random_config(phase % 4);
      for (int n = 0; n < 100; n++) begin
        if (phase != 2 && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 18));
        send_vector(random_component(), random_component(), random_component());
      end
    end
  endtask

  task automatic test_streaming_tail();
    drain_pipeline();
    pick_random_config($urandom_range(0, 3));
    repeat (50) send_vector(random_component(), random_component(), random_component());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_identity_extremes();
    test_quarter_turn();
    test_conjugate_min();
    test_non_unit();
    test_register_masking();
    test_random_phases();
    test_streaming_tail();
    drain_pipeline();
    if (err_count == 0) begin
      $display("quaternion_vector_rotate_tb: done, clean");
    end else begin
      $display("quaternion_vector_rotate_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== quaternion_vector_rotate.f =====
sv/qvr_pkg.sv
sv/qvr_intermediate.sv
sv/qvr_product.sv
sv/qvr_round.sv
sv/quaternion_vector_rotate.sv
test/quaternion_vector_rotate_tb.sv
